// ----- src/pdl_pkg.sv -----
// Package for the pose rate differentiator: state encoding, constants,
// divider handshake types and the quaternion cross-product term table.
// No dependencies.
package pdl_pkg;

   // Configuration register indexes and reset values
   localparam int unsigned CsrIndexWidth = 2;
   typedef logic [CsrIndexWidth-1:0] csr_index_type;
   localparam csr_index_type REG_MIN_INTERVAL = 2'd0;
   localparam csr_index_type REG_MAX_INTERVAL = 2'd1;
   localparam csr_index_type REG_VEL_GAIN     = 2'd2;
   localparam csr_index_type REG_RATE_GAIN    = 2'd3;
   localparam logic [31:0] MIN_INTERVAL_RESET = 32'd100;
   localparam logic [31:0] MAX_INTERVAL_RESET = 32'd2000000;

   // Fixed-point scaling
   localparam int unsigned QUAT_FRAC_BITS = 14;
   localparam int unsigned RATE_FRAC_BITS = 16;
   localparam int unsigned RATE_SHIFT     = 2 * QUAT_FRAC_BITS - RATE_FRAC_BITS;
   localparam logic [21:0] VEL_FACTOR     = 22'd1000000;
   localparam logic [21:0] RATE_FACTOR    = 22'd2000000;
   localparam logic [15:0] ROUND_HALF     = 16'h8000;

   // Divider sizes: magnitude at most 2^32 times a factor below 2^21
   localparam int unsigned DIVIDEND_W = 53;
   localparam int unsigned DIVISOR_W  = 32;
   localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W);

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_QUAT,
      ST_NUM,
      ST_SCALE,
      ST_DIV,
      ST_SAT,
      ST_FILT_OLD,
      ST_FILT_NEW,
      ST_STORE,
      ST_OUT
   } state_type;

   // One term of the vector part of conj(a) * q
   typedef struct packed {
      logic [1:0] a_idx;
      logic [1:0] q_idx;
      logic       sub;
   } quat_term_type;

   function automatic quat_term_type quat_term(input logic [3:0] step);
      quat_term_type t;
      unique case (step)
         4'd0:    t = '{2'd0, 2'd1, 1'b0};
         4'd1:    t = '{2'd1, 2'd0, 1'b1};
         4'd2:    t = '{2'd2, 2'd3, 1'b1};
         4'd3:    t = '{2'd3, 2'd2, 1'b0};
         4'd4:    t = '{2'd0, 2'd2, 1'b0};
         4'd5:    t = '{2'd1, 2'd3, 1'b0};
         4'd6:    t = '{2'd2, 2'd0, 1'b1};
         4'd7:    t = '{2'd3, 2'd1, 1'b1};
         4'd8:    t = '{2'd0, 2'd3, 1'b0};
         4'd9:    t = '{2'd1, 2'd2, 1'b1};
         4'd10:   t = '{2'd2, 2'd1, 1'b0};
         4'd11:   t = '{2'd3, 2'd0, 1'b1};
         default: t = '{2'd0, 2'd0, 1'b0};
      endcase
      return t;
   endfunction

endpackage

// ----- src/pose_rate_differentiator_lowpass.sv -----
// Top level of the pose rate differentiator with first-order lowpass.
// Depends on pdl_pkg and pdl_divider.
//
// Usage: one pose transaction on req_ (timestamp, position, quaternion)
// yields exactly one result transaction on rsp_ (filtered velocity and
// angular rate, with a fresh flag in rsp_tuser). Registers are written over
// the csr_ channel, which is always ready; write them only while idle.
//
// Flow: a sample whose time step is rejected goes from the check straight
// to storing the pose and to the output. An accepted step first forms the
// quaternion products on the shared multiplier, then for each of the six
// axes runs a pass of the shared radix-2 divider plus multiplier steps for
// scaling and, once a first result is loaded, for filtering. The divider
// pass is the longest step. One sample is in work at a time; req_tready is low meanwhile.
//
// The result sits in an output register, so a new sample is accepted while
// the previous result waits; if the receiver still stalls when the next
// result is ready, the block holds it until rsp_tready.
//
// Reset (synchronous, active high) clears the stored pose and filters and
// restores the default interval window and zero gains.
module pose_rate_differentiator_lowpass (
   input  logic                             clock,
   input  logic                             reset,
   // time_us[62:0], pos_x[94:63], pos_y[126:95], pos_z[158:127],
   // quat_w[174:159], quat_x[190:175], quat_y[206:191], quat_z[222:207]
   input  logic [223:0]                     req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // vel_x[31:0], vel_y[63:32], vel_z[95:64],
   // rate_x[127:96], rate_y[159:128], rate_z[191:160]
   output logic [191:0]                     rsp_tdata,
   // fresh[0]
   output logic                             rsp_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  pdl_pkg::csr_index_type           csr_index,
   input  logic [31:0]                      csr_data
);
   import pdl_pkg::*;

   state_type          state_ff, state_in;

   logic [31:0]        min_ff, max_ff;
   logic [15:0]        vgain_ff, rgain_ff;

   logic [62:0]        in_time_ff;
   logic signed [31:0] in_pos_ff [3];
   logic signed [15:0] in_quat_ff [4];
   logic [62:0]        last_time_ff;
   logic signed [31:0] last_pos_ff [3];
   logic signed [15:0] last_quat_ff [4];
   logic signed [31:0] filt_ff [6];
   logic               started_ff;

   logic               ok_ff;
   logic [31:0]        dt_ff;
   logic [3:0]         step_ff;
   logic [2:0]         ch_ff;
   logic signed [33:0] s_ff [3];
   logic               neg_ff;
   logic [32:0]        mag_ff;
   logic signed [31:0] raw_ff;
   logic signed [49:0] acc_ff;

   logic               rsp_valid_ff;
   logic [191:0]       rsp_data_ff;
   logic               rsp_fresh_ff;

   logic               in_accept;
   logic               out_free;
   logic [62:0]        dt_full;
   logic               step_ok;
   quat_term_type      term;
   logic signed [33:0] mul_a;
   logic signed [21:0] mul_b;
   logic signed [55:0] mul_p;
   logic signed [32:0] pos_diff;
   logic signed [33:0] num;
   logic [33:0]        num_mag;
   logic               is_rate;
   logic [15:0]        gain;
   logic [DIVIDEND_W-1:0] quo;
   logic [DIVIDEND_W-1:0] quo_sh;
   logic signed [31:0] sat_val;
   logic signed [49:0] filt_sum;
   logic signed [33:0] s_term;
   div_ctrl_type       div_ctrl;
   div_stat_type       div_stat;

   // Handshakes
   assign in_accept  = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_fresh_ff;

   // Time step window check
   assign dt_full = in_time_ff - last_time_ff;
   assign step_ok = (last_time_ff != '0) && (in_time_ff >= last_time_ff)
                    && (dt_full[62:32] == '0) && (dt_full != '0)
                    && (dt_full[31:0] >= min_ff) && (dt_full[31:0] <= max_ff);

   assign is_rate = (ch_ff >= 3'd3);
   assign gain    = is_rate ? rgain_ff : vgain_ff;
   assign term    = quat_term(step_ff);

   // Numerator of the current axis: position difference or quaternion sum
   assign pos_diff = {in_pos_ff[ch_ff[1:0]][31], in_pos_ff[ch_ff[1:0]]}
                     - {last_pos_ff[ch_ff[1:0]][31], last_pos_ff[ch_ff[1:0]]};
   assign num      = is_rate ? s_ff[2'(ch_ff - 3'd3)] : 34'(pos_diff);
   assign num_mag  = num[33] ? -num : num;

   // Shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_QUAT: begin
            mul_a = 34'(last_quat_ff[term.a_idx]);
            mul_b = 22'(in_quat_ff[term.q_idx]);
         end
         ST_SCALE: begin
            mul_a = {1'b0, mag_ff};
            mul_b = is_rate ? RATE_FACTOR : VEL_FACTOR;
         end
         ST_FILT_OLD: begin
            mul_a = 34'(filt_ff[ch_ff]);
            mul_b = {6'd0, gain};
         end
         ST_FILT_NEW: begin
            mul_a = 34'(raw_ff);
            mul_b = {5'd0, 17'(17'h10000 - {1'b0, gain})};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // Accumulation of the quaternion cross terms
   assign s_term = (step_ff[1:0] == 2'd0) ? '0 : s_ff[step_ff[3:2]];

   // Shift and saturate the quotient
   assign quo_sh = is_rate ? (quo >> RATE_SHIFT) : quo;
   always_comb begin
      if (!neg_ff) begin
         sat_val = (quo_sh > DIVIDEND_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                       : 32'(quo_sh);
      end else begin
         sat_val = (quo_sh > DIVIDEND_W'(32'h8000_0000)) ? 32'sh8000_0000
                                                       : -32'(quo_sh);
      end
   end

   // Filter output with round-half-up floor shift
   assign filt_sum = acc_ff + mul_p[49:0] + 50'(ROUND_HALF);

   assign div_ctrl.start = (state_ff == ST_SCALE);

   pdl_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (mul_p[DIVIDEND_W-1:0]),
      .divisor  (dt_ff),
      .stat     (div_stat),
      .quotient (quo)
   );

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and ready
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = ST_CHECK;
         end
         ST_CHECK:    state_in = step_ok ? ST_QUAT : ST_STORE;
         ST_QUAT:     if (step_ff == 4'd11) state_in = ST_NUM;
         ST_NUM:      state_in = ST_SCALE;
         ST_SCALE:    state_in = ST_DIV;
         ST_DIV:      if (div_stat.done) state_in = ST_SAT;
         ST_SAT: begin
            if (started_ff) begin
               state_in = ST_FILT_OLD;
            end else begin
               state_in = (ch_ff == 3'd5) ? ST_STORE : ST_NUM;
            end
         end
         ST_FILT_OLD: state_in = ST_FILT_NEW;
         ST_FILT_NEW: state_in = (ch_ff == 3'd5) ? ST_STORE : ST_NUM;
         ST_STORE:    state_in = ST_OUT;
         ST_OUT:      if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= MIN_INTERVAL_RESET;
         max_ff   <= MAX_INTERVAL_RESET;
         vgain_ff <= '0;
         rgain_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MIN_INTERVAL: min_ff   <= csr_data;
            REG_MAX_INTERVAL: max_ff   <= csr_data;
            REG_VEL_GAIN:     vgain_ff <= csr_data[15:0];
            REG_RATE_GAIN:    rgain_ff <= csr_data[15:0];
         endcase
      end
   end

   // Sample capture and working registers
   always_ff @(posedge clock) begin
      if (in_accept) begin
         in_time_ff    <= req_tdata[62:0];
         in_pos_ff[0]  <= req_tdata[94:63];
         in_pos_ff[1]  <= req_tdata[126:95];
         in_pos_ff[2]  <= req_tdata[158:127];
         in_quat_ff[0] <= req_tdata[174:159];
         in_quat_ff[1] <= req_tdata[190:175];
         in_quat_ff[2] <= req_tdata[206:191];
         in_quat_ff[3] <= req_tdata[222:207];
      end
      unique case (state_ff)
         ST_CHECK: begin
            ok_ff   <= step_ok;
            dt_ff   <= dt_full[31:0];
            step_ff <= '0;
         end
         ST_QUAT: begin
            s_ff[step_ff[3:2]] <= term.sub ? s_term - mul_p[33:0]
                                           : s_term + mul_p[33:0];
            step_ff <= step_ff + 1'b1;
         end
         ST_NUM: begin
            neg_ff <= num[33];
            mag_ff <= num_mag[32:0];
         end
         ST_SAT:      raw_ff <= sat_val;
         ST_FILT_OLD: acc_ff <= mul_p[49:0];
         default: ;
      endcase
   end

   // Filter state, stored pose and axis counter
   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         started_ff   <= 1'b0;
         for (int i = 0; i < 3; i++) last_pos_ff[i] <= '0;
         for (int i = 0; i < 4; i++) last_quat_ff[i] <= '0;
         for (int i = 0; i < 6; i++) filt_ff[i] <= '0;
      end else begin
         if (state_ff == ST_CHECK) begin
            ch_ff <= '0;
         end
         if (state_ff == ST_SAT && !started_ff) begin
            filt_ff[ch_ff] <= sat_val;
            ch_ff          <= ch_ff + 1'b1;
         end
         if (state_ff == ST_FILT_NEW) begin
            filt_ff[ch_ff] <= filt_sum[47:16];
            ch_ff          <= ch_ff + 1'b1;
         end
         if (state_ff == ST_STORE) begin
            last_time_ff <= in_time_ff;
            started_ff   <= started_ff || ok_ff;
            for (int i = 0; i < 3; i++) last_pos_ff[i] <= in_pos_ff[i];
            for (int i = 0; i < 4; i++) last_quat_ff[i] <= in_quat_ff[i];
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_data_ff  <= {filt_ff[5], filt_ff[4], filt_ff[3],
                          filt_ff[2], filt_ff[1], filt_ff[0]};
         rsp_fresh_ff <= ok_ff;
      end
   end

endmodule

// ----- src/pdl_divider.sv -----
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on pdl_pkg.
module pdl_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  pdl_pkg::div_ctrl_type            ctrl,
   input  logic [pdl_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [pdl_pkg::DIVISOR_W-1:0]    divisor,
   output pdl_pkg::div_stat_type            stat,
   output logic [pdl_pkg::DIVIDEND_W-1:0]   quotient
);
   import pdl_pkg::*;

   logic [DIVISOR_W:0]    rem_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   // Shift in the next dividend bit and try a subtraction
   assign trial = {rem_ff[DIVISOR_W-1:0], quo_ff[DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   // Control: a start runs DIVIDEND_W iterations, then flags done for a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIVIDEND_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: partial remainder and quotient shift register
   always_ff @(posedge clock) begin
      if (ctrl.start && !busy_ff) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial - {1'b0, divisor} : trial;
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

// ----- src/pdl_checker.sv -----
// Port-level checks for the pose rate differentiator, bound to its top level.
// Depends on the port list of pose_rate_differentiator_lowpass.
module pdl_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [191:0]           rsp_tdata,
   input logic                   rsp_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic                   csr_ready
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result payload changed while stalled");

   // The block works on one sample at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second sample accepted while busy");

   // No result is offered straight after an acceptance made with none pending
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared the cycle after acceptance");

   // Configuration is never back-pressured
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration channel not ready");

endmodule

bind pose_rate_differentiator_lowpass pdl_checker u_pdl_checker (.*);

// ----- tb/tb.sv -----
// Testbench for pose_rate_differentiator_lowpass: a directed table, then
// random pose streams under several register settings and idling phases.
// Depends on pdl_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;
   import pdl_pkg::*;

   typedef struct packed {
      logic [62:0] t;
      logic [31:0] px, py, pz;
      logic [15:0] qw, qx, qy, qz;
   } pose_type;

   typedef struct packed {
      logic        fresh;
      logic [31:0] vx, vy, vz, rx, ry, rz;
   } motion_type;

   typedef struct {
      pose_type   pose;
      bit         known;
      motion_type res;
   } pose_row_type;

   localparam longint unsigned TimeMask = 64'h7FFF_FFFF_FFFF_FFFF;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [223:0] req_tdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   csr_index_type csr_index = REG_MIN_INTERVAL;
   logic [31:0]  csr_data = '0;

   pose_rate_differentiator_lowpass u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #50ms;
      $display("Some tests failed");
      $finish;
   end

   // Register copies and stored pose of the predictor
   longint unsigned win_min, win_max;
   int unsigned     vel_gain, rate_gain;
   longint unsigned prev_time;
   longint          prev_pos[3];
   longint          prev_quat[4];
   longint          filt_vel[3];
   longint          filt_rate[3];
   bit              filt_loaded;

   motion_type expected_motion[$];
   pose_row_type pose_table[$];
   int  fail_count = 0;
   int  sender_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_req = 0;
   longint unsigned sent_time = 0;
   pose_type last_sent = '0;

   // Magnitude scaled by factor, divided by the step, shifted and saturated.
   function automatic longint scaled_derivative(longint num, longint unsigned factor,
                                                longint unsigned dt, int sh);
      bit neg;
      longint unsigned mag, q;
      neg = num < 0;
      mag = neg ? longint'(-num) : num;
      q = ((mag * factor) / dt) >> sh;
      if (!neg) return (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
      return (q > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(q);
   endfunction

   function automatic longint lowpass_step(int unsigned g, longint old, longint x);
      longint acc;
      acc = longint'(g) * old + longint'(65536 - g) * x + 32768;
      return acc >>> 16;
   endfunction

   // Advances the predictor by one pose and returns the expected motion.
   function automatic motion_type predict_motion(pose_type p);
      longint unsigned t, dt;
      longint pos[3], quat[4], s[3], v[3], r[3];
      bit ok;
      motion_type m;
      t = p.t;
      pos[0] = longint'(signed'(p.px));
      pos[1] = longint'(signed'(p.py));
      pos[2] = longint'(signed'(p.pz));
      quat[0] = longint'(signed'(p.qw));
      quat[1] = longint'(signed'(p.qx));
      quat[2] = longint'(signed'(p.qy));
      quat[3] = longint'(signed'(p.qz));
      ok = prev_time != 0 && t >= prev_time;
      dt = ok ? t - prev_time : 0;
      ok = ok && dt != 0 && dt >= win_min && dt <= win_max;
      if (ok) begin
         s[0] = prev_quat[0]*quat[1] - prev_quat[1]*quat[0]
              - prev_quat[2]*quat[3] + prev_quat[3]*quat[2];
         s[1] = prev_quat[0]*quat[2] + prev_quat[1]*quat[3]
              - prev_quat[2]*quat[0] - prev_quat[3]*quat[1];
         s[2] = prev_quat[0]*quat[3] - prev_quat[1]*quat[2]
              + prev_quat[2]*quat[1] - prev_quat[3]*quat[0];
         for (int i = 0; i < 3; i++) begin
            v[i] = scaled_derivative(pos[i] - prev_pos[i], 1000000, dt, 0);
            r[i] = scaled_derivative(s[i], 2000000, dt, RATE_SHIFT);
            filt_vel[i]  = filt_loaded ? lowpass_step(vel_gain, filt_vel[i], v[i]) : v[i];
            filt_rate[i] = filt_loaded ? lowpass_step(rate_gain, filt_rate[i], r[i]) : r[i];
         end
         filt_loaded = 1;
      end
      prev_time = t;
      prev_pos = pos;
      prev_quat = quat;
      m.fresh = ok;
      m.vx = filt_vel[0][31:0];
      m.vy = filt_vel[1][31:0];
      m.vz = filt_vel[2][31:0];
      m.rx = filt_rate[0][31:0];
      m.ry = filt_rate[1][31:0];
      m.rz = filt_rate[2][31:0];
      return m;
   endfunction

   // Offers one pose and waits for its transaction; the expectation is queued.
   task automatic send_pose(pose_type p, bit known, motion_type typed);
      motion_type m;
      req_tdata  <= {1'b0, p.qz, p.qy, p.qx, p.qw, p.pz, p.py, p.px, p.t};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      m = predict_motion(p);
      expected_motion.push_back(known ? typed : m);
      last_sent = p;
      sent_time = p.t;
   endtask

   task automatic sender_gap();
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_motion.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_MIN_INTERVAL: win_min = value;
         REG_MAX_INTERVAL: win_max = value;
         REG_VEL_GAIN:     vel_gain = value[15:0];
         default:          rate_gain = value[15:0];
      endcase
      @(posedge clock);
   endtask

   task automatic add_row(logic [62:0] t, logic [31:0] px, py, pz,
                          logic [15:0] qw, qx, qy, qz, bit known, motion_type res);
      pose_row_type row;
      row.pose = '{t, px, py, pz, qw, qx, qy, qz};
      row.known = known;
      row.res = res;
      pose_table.push_back(row);
   endtask

   // Next timestamp: mostly inside the window, the rest at and beyond its edges, backwards, random or zero.
   function automatic logic [62:0] next_time();
      longint unsigned lo, hi, dt;
      int sel;
      lo = (win_min == 0) ? 1 : win_min;
      hi = win_max;
      if (lo > hi) hi = lo + 2000;
      sel = $urandom_range(99);
      if (sel < 60)      dt = lo + $urandom_range((hi - lo > 3000) ? 3000 : hi - lo);
      else if (sel < 68) dt = lo;
      else if (sel < 76) dt = hi;
      else if (sel < 82) dt = hi + 1;
      else if (sel < 86) dt = lo - 1;
      else if (sel < 90) dt = 0;
      else if (sel < 94) return 63'((sent_time - $urandom_range(1, 500)) & TimeMask);
      else if (sel < 97) return 63'({$urandom, $urandom});
      else return '0;
      return 63'((sent_time + dt) & TimeMask);
   endfunction

   function automatic logic [31:0] next_coord(logic [31:0] old);
      if ($urandom_range(99) < 80) return old + 32'($signed($urandom_range(4000)) - 2000);
      return $urandom;
   endfunction

   function automatic logic [15:0] next_quat(logic [15:0] old);
      int sel;
      sel = $urandom_range(99);
      if (sel < 60) return old + 16'($signed($urandom_range(400)) - 200);
      if (sel < 85) return 16'($signed($urandom_range(32768)) - 16384);
      return 16'($urandom);
   endfunction

   task automatic random_poses(int count, bit with_hold);
      pose_type p;
      for (int n = 0; n < count; n++) begin
         p.t  = next_time();
         p.px = next_coord(last_sent.px);
         p.py = next_coord(last_sent.py);
         p.pz = next_coord(last_sent.pz);
         p.qw = next_quat(last_sent.qw);
         p.qx = next_quat(last_sent.qx);
         p.qy = next_quat(last_sent.qy);
         p.qz = next_quat(last_sent.qz);
         if (with_hold && n == 20) hold_req = 1;
         send_pose(p, 0, '0);
         sender_gap();
      end
   endtask

   // Receiver: random stalls, plus a long hold-off when asked for.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 0;
            rsp_tready <= 1'b0;
            for (int c = 0; c < 3000; c++) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Result check against the oldest expectation, field by field.
   always @(posedge clock) begin
      motion_type want, got;
      string names[6];
      if (!reset && rsp_tvalid && rsp_tready) begin
         names = '{"vel_x", "vel_y", "vel_z", "rate_x", "rate_y", "rate_z"};
         got.fresh = rsp_tuser;
         {got.rz, got.ry, got.rx, got.vz, got.vy, got.vx} = rsp_tdata;
         if (expected_motion.size() == 0) begin
            $error("unexpected result transaction");
            fail_count++;
         end else begin
            want = expected_motion.pop_front();
            for (int i = 0; i < 6; i++)
               if (want[32*(5-i) +: 32] !== got[32*(5-i) +: 32]) begin
                  $error("%s expected %0d actual %0d", names[i],
                         $signed(want[32*(5-i) +: 32]), $signed(got[32*(5-i) +: 32]));
                  fail_count++;
               end
            if (want.fresh !== got.fresh) begin
               $error("fresh expected %0d actual %0d", want.fresh, got.fresh);
               fail_count++;
            end
         end
      end
   end

   initial begin
      motion_type zero_old, zero_new, sat_step;
      win_min = MIN_INTERVAL_RESET;
      win_max = MAX_INTERVAL_RESET;
      vel_gain = 0;
      rate_gain = 0;
      prev_time = 0;
      prev_pos = '{0, 0, 0};
      prev_quat = '{0, 0, 0, 0};
      filt_vel = '{0, 0, 0};
      filt_rate = '{0, 0, 0};
      filt_loaded = 0;

      zero_old = '0;
      zero_new = '0;
      zero_new.fresh = 1'b1;
      sat_step = '{1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h0, 32'h0};

      // First sample, a repeat, short step, then an accepted step with no motion
      add_row(1000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              16'h7FFF, 16'h0, 16'h0, 16'h0, 1, zero_old);
      add_row(1000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              16'h7FFF, 16'h0, 16'h0, 16'h0, 1, zero_old);
      add_row(1001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              16'h7FFF, 16'h0, 16'h0, 16'h0, 1, zero_old);
      add_row(1101, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              16'h7FFF, 16'h0, 16'h0, 16'h0, 1, zero_new);
      // Time running backwards, then a jump from the top to the bottom of range
      add_row(500, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              16'h7FFF, 16'h0, 16'h0, 16'h0, 1, zero_old);
      add_row(600, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              16'h0, 16'h7FFF, 16'h0, 16'h0, 1, sat_step);
      // Window edges, a timestamp of zero and the largest timestamp
      add_row(2000600, 32'h0001_0000, 32'hFFFF_0000, 32'h0,
              16'h4000, 16'h0, 16'h0, 16'h0, 0, '0);
      add_row(4000601, 32'h0002_0000, 32'hFFFE_0000, 32'h1,
              16'h4000, 16'h0, 16'h0, 16'h0, 0, '0);
      add_row(4000700, 32'h0003_0000, 32'h0, 32'hFFFF_FFFF,
              16'h3FFF, 16'h0100, 16'hFF00, 16'h0010, 0, '0);
      add_row(0, 32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, '0);
      add_row(200, 32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, '0);
      add_row(300, 32'h1234_5678, 32'hEDCB_A988, 32'h0000_0001,
              16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 0, '0);
      add_row(63'h7FFF_FFFF_FFFF_FFFF, 32'h0, 32'h0, 32'h0,
              16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, '0);
      add_row(63'h7FFF_FFFF_FFFF_FFFF, 32'h0, 32'h0, 32'h0,
              16'hC000, 16'h4000, 16'hC000, 16'h4000, 0, '0);
      add_row(450, 32'h0, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 0, '0);
      add_row(551, 32'h0000_8000, 32'hFFFF_8000, 32'h0,
              16'h3FF0, 16'h0200, 16'hFE00, 16'h0100, 0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (pose_table[i]) begin
         send_pose(pose_table[i].pose, pose_table[i].known, pose_table[i].res);
         sender_gap();
      end
      random_poses(384, 0);
      drain();

      // Filtered, narrow window, sender idling
      write_reg(REG_VEL_GAIN, 32'h8000);
      write_reg(REG_RATE_GAIN, 32'h4000);
      write_reg(REG_MIN_INTERVAL, 32'd50);
      write_reg(REG_MAX_INTERVAL, 32'd5000);
      sender_idle_pct = 60;
      random_poses(270, 0);
      drain();

      // Widest window and heaviest filtering, receiver stalling
      write_reg(REG_MIN_INTERVAL, 32'd0);
      write_reg(REG_MAX_INTERVAL, 32'hFFFF_FFFF);
      write_reg(REG_VEL_GAIN, 32'hFFFF);
      write_reg(REG_RATE_GAIN, 32'hFFFF);
      sender_idle_pct = 0;
      recv_stall_pct = 60;
      random_poses(270, 0);
      drain();

      // Inverted window: nothing is accepted
      write_reg(REG_MIN_INTERVAL, 32'd1000);
      write_reg(REG_MAX_INTERVAL, 32'd10);
      sender_idle_pct = 22;
      recv_stall_pct = 22;
      random_poses(120, 0);
      drain();

      // Single-value window, with a long receiver hold-off
      write_reg(REG_MIN_INTERVAL, 32'd300);
      write_reg(REG_MAX_INTERVAL, 32'd300);
      write_reg(REG_VEL_GAIN, 32'd1);
      write_reg(REG_RATE_GAIN, 32'h7FFF);
      sender_idle_pct = 0;
      recv_stall_pct = 0;
      random_poses(270, 1);
      drain();

      // Short window with random gains, both sides idling
      write_reg(REG_MIN_INTERVAL, 32'd1);
      write_reg(REG_MAX_INTERVAL, 32'd1000);
      write_reg(REG_VEL_GAIN, $urandom_range(65535));
      write_reg(REG_RATE_GAIN, $urandom_range(65535));
      sender_idle_pct = 22;
      recv_stall_pct = 22;
      random_poses(270, 0);
      drain();
      repeat (50) @(posedge clock);

      if (fail_count == 0 && expected_motion.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- sim.f -----
src/pdl_pkg.sv
src/pdl_divider.sv
src/pose_rate_differentiator_lowpass.sv
src/pdl_checker.sv
tb/tb.sv
